// ===== rtl/core/lsfs_pkg.sv =====
// ============================================================================
// lsfs_pkg: shared types and constants for the LED strip fade serializer
// Request kinds, register indexes, field widths and the control structs
// passed between the buffer engine, the waveform timer and the top level.
// ============================================================================
package lsfs_pkg;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 8;
    localparam int NUMB_W     = 9;
    localparam int TICK_W     = 10;
    localparam int GAP_W      = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Request kinds
    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_TICK   = 2'd0;
    localparam kind_t KIND_DIRECT = 2'd1;
    localparam kind_t KIND_TARGET = 2'd2;
    localparam kind_t KIND_STEP   = 2'd3;

    // Register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_BYTE_CNT    = 3'd0;
    localparam cfg_idx_t CFG_BIT_PERIOD  = 3'd1;
    localparam cfg_idx_t CFG_ONE_HIGH    = 3'd2;
    localparam cfg_idx_t CFG_ZERO_HIGH   = 3'd3;
    localparam cfg_idx_t CFG_LATCH_TICKS = 3'd4;

    // Register reset values
    localparam logic [NUMB_W-1:0] BYTE_CNT_RST    = 9'd3;
    localparam logic [TICK_W-1:0] BIT_PERIOD_RST  = 10'd20;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST    = 10'd13;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST   = 10'd6;
    localparam logic [GAP_W-1:0]  LATCH_TICKS_RST = 16'd800;

    typedef struct packed {
        logic [NUMB_W-1:0] byte_cnt;
        logic [TICK_W-1:0] bit_period;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] zero_high;
        logic [GAP_W-1:0]  latch_ticks;
    } cfg_t;

    // Commands from the top level to the buffer engine
    typedef struct packed {
        logic wr_direct;
        logic wr_target;
        logic start_step;
        logic start_fetch;
        logic advance;
    } buf_cmd_t;

    // Commands from the top level to the waveform timer
    typedef struct packed {
        logic tick;
        logic frame;
    } wave_cmd_t;

    // Status from the waveform timer
    typedef struct packed {
        logic level;
        logic busy;
        logic busy_after_tick;
        logic advance;
    } wave_stat_t;

endpackage

// ===== rtl/core/lsfs_item_if.sv =====
// ============================================================================
// lsfs_item_if: input request channel
// Valid/ready channel carrying one request: kind, byte index, value, last.
// ============================================================================
interface lsfs_item_if;
    logic                           valid;
    logic                           ready;
    logic [lsfs_pkg::KIND_W-1:0]    kind;
    logic [lsfs_pkg::IDX_W-1:0]     index;
    logic [lsfs_pkg::BYTE_W-1:0]    value;
    logic                           last;

    modport source (output valid, output kind, output index, output value, output last,
                    input ready);
    modport sink   (input valid, input kind, input index, input value, input last,
                    output ready);
endinterface

// ===== rtl/core/lsfs_result_if.sv =====
// ============================================================================
// lsfs_result_if: result channel
// Valid/ready channel carrying the line level, busy flag and reject flag.
// ============================================================================
interface lsfs_result_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic rejected;

    modport source (output valid, output line_level, output busy_res, output rejected,
                    input ready);
    modport sink   (input valid, input line_level, input busy_res, input rejected,
                    output ready);
endinterface

// ===== rtl/core/lsfs_cfg_if.sv =====
// ============================================================================
// lsfs_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ============================================================================
interface lsfs_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lsfs_pkg::CFG_IDX_W-1:0]     index;
    logic [lsfs_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/lsfs_ram.sv =====
// ============================================================================
// lsfs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module lsfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/lsfs_buf.sv =====
// ============================================================================
// lsfs_buf: strip byte buffer engine
// Holds the current and target byte memories. Clears them after reset, runs
// the smooth step as a read-modify-write sweep, and prefetches the bytes that
// the waveform timer shifts out.
// ============================================================================
module lsfs_buf #(
    parameter  int MAX_BYTES = 256,
    localparam int AW        = $clog2(MAX_BYTES),
    localparam int CW        = $clog2(MAX_BYTES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsfs_pkg::buf_cmd_t            cmd,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [lsfs_pkg::BYTE_W-1:0]   wr_value,
    input  logic [CW-1:0]                 n_bytes,
    input  logic [AW-1:0]                 adv_addr,
    output logic                          ready,
    output logic [lsfs_pkg::BYTE_W-1:0]   cur_byte
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_FETCH0,
        ST_FETCH1
    } state_t;

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 ptr_reg, ptr_next;
    logic                          s1_valid_reg, s1_valid_next;
    logic [AW-1:0]                 s1_addr_reg, s1_addr_next;
    logic [lsfs_pkg::BYTE_W-1:0]   cur_byte_reg, cur_byte_next;
    logic [lsfs_pkg::BYTE_W-1:0]   nxt_byte_reg, nxt_byte_next;
    logic                          nxt_pend_reg, nxt_pend_next;

    logic                          cur_wr_en, tgt_wr_en;
    logic [AW-1:0]                 cur_wr_addr, tgt_wr_addr;
    logic [lsfs_pkg::BYTE_W-1:0]   cur_wr_data, tgt_wr_data;
    logic                          cur_rd_en, tgt_rd_en;
    logic [AW-1:0]                 cur_rd_addr, tgt_rd_addr;
    logic [lsfs_pkg::BYTE_W-1:0]   cur_rd_data, tgt_rd_data;
    logic [lsfs_pkg::BYTE_W-1:0]   stepped;

    lsfs_ram #(
        .WIDTH (lsfs_pkg::BYTE_W),
        .DEPTH (MAX_BYTES)
    ) u_cur_ram (
        .clk     (clk),
        .wr_en   (cur_wr_en),
        .wr_addr (cur_wr_addr),
        .wr_data (cur_wr_data),
        .rd_en   (cur_rd_en),
        .rd_addr (cur_rd_addr),
        .rd_data (cur_rd_data)
    );

    lsfs_ram #(
        .WIDTH (lsfs_pkg::BYTE_W),
        .DEPTH (MAX_BYTES)
    ) u_tgt_ram (
        .clk     (clk),
        .wr_en   (tgt_wr_en),
        .wr_addr (tgt_wr_addr),
        .wr_data (tgt_wr_data),
        .rd_en   (tgt_rd_en),
        .rd_addr (tgt_rd_addr),
        .rd_data (tgt_rd_data)
    );

    // Move the fetched current byte one count toward its target
    always_comb
    begin
        if (cur_rd_data < tgt_rd_data)
        begin
            stepped = cur_rd_data + 8'd1;
        end
        else if (cur_rd_data > tgt_rd_data)
        begin
            stepped = cur_rd_data - 8'd1;
        end
        else
        begin
            stepped = cur_rd_data;
        end
    end

    // Sequence the memory ports
    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        s1_valid_next = s1_valid_reg;
        s1_addr_next  = s1_addr_reg;
        cur_byte_next = cur_byte_reg;
        nxt_byte_next = nxt_byte_reg;
        nxt_pend_next = nxt_pend_reg;

        cur_wr_en   = 1'b0;
        cur_wr_addr = wr_addr;
        cur_wr_data = wr_value;
        tgt_wr_en   = 1'b0;
        tgt_wr_addr = wr_addr;
        tgt_wr_data = wr_value;
        cur_rd_en   = 1'b0;
        cur_rd_addr = adv_addr;
        tgt_rd_en   = 1'b0;
        tgt_rd_addr = ptr_reg[AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one entry of each memory per cycle
                cur_wr_en   = 1'b1;
                cur_wr_addr = ptr_reg[AW-1:0];
                cur_wr_data = '0;
                tgt_wr_en   = 1'b1;
                tgt_wr_addr = ptr_reg[AW-1:0];
                tgt_wr_data = '0;
                if (ptr_reg == CW'(MAX_BYTES - 1))
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            ST_IDLE:
            begin
                // Capture the prefetched next byte
                if (nxt_pend_reg)
                begin
                    nxt_byte_next = cur_rd_data;
                    nxt_pend_next = 1'b0;
                end
                cur_wr_en = cmd.wr_direct;
                tgt_wr_en = cmd.wr_direct | cmd.wr_target;
                // Advance to the next byte and prefetch the one after it
                if (cmd.advance)
                begin
                    cur_byte_next = nxt_byte_reg;
                    cur_rd_en     = 1'b1;
                    cur_rd_addr   = adv_addr;
                    nxt_pend_next = 1'b1;
                end
                if (cmd.start_step)
                begin
                    ptr_next      = '0;
                    s1_valid_next = 1'b0;
                    state_next    = ST_STEP;
                end
                else if (cmd.start_fetch)
                begin
                    state_next = ST_FETCH0;
                end
            end
            ST_STEP:
            begin
                // Read entry ptr, write back the entry read in the cycle before
                if (s1_valid_reg)
                begin
                    cur_wr_en   = 1'b1;
                    cur_wr_addr = s1_addr_reg;
                    cur_wr_data = stepped;
                end
                if (ptr_reg < n_bytes)
                begin
                    cur_rd_en     = 1'b1;
                    cur_rd_addr   = ptr_reg[AW-1:0];
                    tgt_rd_en     = 1'b1;
                    s1_valid_next = 1'b1;
                    s1_addr_next  = ptr_reg[AW-1:0];
                    ptr_next      = ptr_reg + CW'(1);
                end
                else
                begin
                    s1_valid_next = 1'b0;
                    if (!s1_valid_reg)
                    begin
                        state_next = ST_FETCH0;
                    end
                end
            end
            ST_FETCH0:
            begin
                // Read the first byte of the frame
                cur_rd_en   = 1'b1;
                cur_rd_addr = '0;
                state_next  = ST_FETCH1;
            end
            ST_FETCH1:
            begin
                // Hold the first byte, prefetch the second
                cur_byte_next = cur_rd_data;
                cur_rd_en     = 1'b1;
                cur_rd_addr   = AW'(1);
                nxt_pend_next = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            ptr_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_addr_reg  <= '0;
            cur_byte_reg <= '0;
            nxt_byte_reg <= '0;
            nxt_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            s1_valid_reg <= s1_valid_next;
            s1_addr_reg  <= s1_addr_next;
            cur_byte_reg <= cur_byte_next;
            nxt_byte_reg <= nxt_byte_next;
            nxt_pend_reg <= nxt_pend_next;
        end
    end

    assign ready    = (state_reg == ST_IDLE);
    assign cur_byte = cur_byte_reg;

endmodule

// ===== rtl/core/lsfs_wave.sv =====
// ============================================================================
// lsfs_wave: single-wire waveform timer
// Tracks the latch gap, the bit and byte position of a frame and the tick
// within a bit, and derives the line level from the byte being sent.
// ============================================================================
module lsfs_wave #(
    parameter  int MAX_BYTES = 256,
    localparam int AW        = $clog2(MAX_BYTES),
    localparam int CW        = $clog2(MAX_BYTES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsfs_pkg::cfg_t                cfg,
    input  logic [CW-1:0]                 n_bytes,
    input  logic [lsfs_pkg::BYTE_W-1:0]   cur_byte,
    input  lsfs_pkg::wave_cmd_t           cmd,
    output lsfs_pkg::wave_stat_t          stat,
    output logic [AW-1:0]                 adv_addr
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LATCH,
        PH_SEND
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [CW-1:0]                 send_index_reg, send_index_next;
    logic [2:0]                    bit_count_reg, bit_count_next;
    logic [lsfs_pkg::TICK_W-1:0]   tick_in_bit_reg, tick_in_bit_next;
    logic [lsfs_pkg::GAP_W-1:0]    gap_reg, gap_next;

    logic [lsfs_pkg::TICK_W-1:0]   tick_inc;
    logic                          bit_end;
    logic                          byte_done;
    logic [CW-1:0]                 index_inc;
    logic [CW:0]                   index_plus2;
    logic [lsfs_pkg::GAP_W-1:0]    gap_dec;
    logic                          cur_bit;
    logic [lsfs_pkg::TICK_W-1:0]   high_ticks;

    // Line level for the bit in flight
    assign cur_bit    = cur_byte[3'd7 - bit_count_reg];
    assign high_ticks = cur_bit ? cfg.one_high : cfg.zero_high;

    assign tick_inc    = tick_in_bit_reg + 10'd1;
    assign bit_end     = (tick_inc >= cfg.bit_period) || (tick_inc == '0);
    assign index_inc   = send_index_reg + CW'(1);
    assign index_plus2 = {1'b0, send_index_reg} + (CW + 1)'(2);
    assign gap_dec     = (gap_reg != '0) ? gap_reg - 16'd1 : gap_reg;

    // Advance the waveform on ticks, restart it on frame requests
    always_comb
    begin
        phase_next       = phase_reg;
        send_index_next  = send_index_reg;
        bit_count_next   = bit_count_reg;
        tick_in_bit_next = tick_in_bit_reg;
        gap_next         = gap_reg;
        byte_done        = 1'b0;

        if (cmd.frame)
        begin
            send_index_next  = '0;
            bit_count_next   = '0;
            tick_in_bit_next = '0;
            phase_next       = (gap_reg == '0) ? PH_SEND : PH_LATCH;
        end
        else if (cmd.tick)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    gap_next = gap_dec;
                end
                PH_LATCH:
                begin
                    gap_next = gap_dec;
                    if (gap_dec == '0)
                    begin
                        phase_next = PH_SEND;
                    end
                end
                PH_SEND:
                begin
                    if (bit_end)
                    begin
                        tick_in_bit_next = '0;
                        bit_count_next   = bit_count_reg + 3'd1;
                        if (bit_count_reg == 3'd7)
                        begin
                            // Byte done: move on or close the frame
                            byte_done       = 1'b1;
                            send_index_next = index_inc;
                            if (index_inc >= n_bytes)
                            begin
                                phase_next      = PH_IDLE;
                                send_index_next = '0;
                                gap_next        = cfg.latch_ticks;
                            end
                        end
                    end
                    else
                    begin
                        tick_in_bit_next = tick_inc;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            send_index_reg  <= '0;
            bit_count_reg   <= '0;
            tick_in_bit_reg <= '0;
            gap_reg         <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            send_index_reg  <= send_index_next;
            bit_count_reg   <= bit_count_next;
            tick_in_bit_reg <= tick_in_bit_next;
            gap_reg         <= gap_next;
        end
    end

    assign stat.level           = (phase_reg == PH_SEND) && (tick_in_bit_reg < high_ticks);
    assign stat.busy            = (phase_reg != PH_IDLE);
    assign stat.busy_after_tick = (phase_next != PH_IDLE);
    assign stat.advance         = byte_done;
    assign adv_addr             = index_plus2[AW-1:0];

endmodule

// ===== rtl/core/led_strip_fade_serializer.sv =====
// ============================================================================
// led_strip_fade_serializer: LED strip driver with smooth fading
// Top level: register file, request decode, result register, and the buffer
// engine and waveform timer.
// ============================================================================
// Usage: every request returns exactly one result. Tick requests and plain byte
// writes can be taken back to back while results are being taken. A direct
// write with last set then passes through the fetch states, in which the first
// two bytes of the frame are read from the current-byte memory. A smooth step
// runs a read-modify-write sweep over the current and target memories for the
// byte count in use, one byte a cycle, then drains the write-back and does the
// same two-byte prefetch. After reset the block clears both memories before it
// takes its first request; register writes are taken at any time. During a
// frame each tick request advances the line by one tick, and the next color
// byte is fetched from memory while the current one shifts out.
module led_strip_fade_serializer #(
    parameter int MAX_BYTES = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    lsfs_cfg_if.sink        cfg,
    lsfs_item_if.sink       item,
    lsfs_result_if.source   result
);

    localparam int AW  = $clog2(MAX_BYTES);
    localparam int CW  = $clog2(MAX_BYTES + 1);
    localparam int NCW = (CW > lsfs_pkg::NUMB_W) ? CW : lsfs_pkg::NUMB_W;
    localparam int IXW = (AW > lsfs_pkg::IDX_W) ? AW : lsfs_pkg::IDX_W;

    lsfs_pkg::cfg_t        cfg_reg, cfg_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  line_level_reg, line_level_next;
    logic                  busy_res_reg, busy_res_next;
    logic                  rejected_reg, rejected_next;

    lsfs_pkg::buf_cmd_t    buf_cmd;
    lsfs_pkg::wave_cmd_t   wave_cmd;
    lsfs_pkg::wave_stat_t  wave_stat;
    logic                  buf_ready;
    logic [lsfs_pkg::BYTE_W-1:0] cur_byte;
    logic [AW-1:0]         adv_addr;
    logic [CW-1:0]         n_bytes;
    logic [NCW-1:0]        num_ext;
    logic [IXW-1:0]        index_ext;
    logic                  index_ok;
    logic                  accept;
    logic                  busy_after;

    // Saturate the byte count to 1..MAX_BYTES
    assign num_ext = NCW'(cfg_reg.byte_cnt);
    always_comb
    begin
        if (num_ext == '0)
        begin
            n_bytes = CW'(1);
        end
        else if (num_ext > NCW'(MAX_BYTES))
        begin
            n_bytes = CW'(MAX_BYTES);
        end
        else
        begin
            n_bytes = num_ext[CW-1:0];
        end
    end

    assign index_ext = IXW'(item.index);
    assign index_ok  = (IXW + 1)'(index_ext) < (IXW + 1)'(MAX_BYTES);

    // Take a request when the buffer engine is free and the result slot drains
    assign item.ready = buf_ready && (!out_valid_reg || result.ready);
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // Decode the request
    always_comb
    begin
        buf_cmd    = '0;
        wave_cmd   = '0;
        busy_after = 1'b0;
        buf_cmd.advance = accept && wave_stat.advance;
        case (item.kind)
            lsfs_pkg::KIND_TICK:
            begin
                wave_cmd.tick = accept;
                busy_after    = wave_stat.busy_after_tick;
            end
            lsfs_pkg::KIND_DIRECT:
            begin
                if (!wave_stat.busy)
                begin
                    buf_cmd.wr_direct   = accept && index_ok;
                    buf_cmd.start_fetch = accept && item.last;
                    wave_cmd.frame      = accept && item.last;
                    busy_after          = item.last;
                end
            end
            lsfs_pkg::KIND_TARGET:
            begin
                if (!wave_stat.busy)
                begin
                    buf_cmd.wr_target = accept && index_ok;
                end
            end
            lsfs_pkg::KIND_STEP:
            begin
                if (!wave_stat.busy)
                begin
                    buf_cmd.start_step = accept;
                    wave_cmd.frame     = accept;
                    busy_after         = 1'b1;
                end
            end
            default:
            begin
                busy_after = 1'b0;
            end
        endcase
    end

    // Result register and register file
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        line_level_next = line_level_reg;
        busy_res_next   = busy_res_reg;
        rejected_next   = rejected_reg;
        cfg_next        = cfg_reg;

        if (accept)
        begin
            out_valid_next  = 1'b1;
            line_level_next = wave_stat.level;
            busy_res_next   = wave_stat.busy || busy_after;
            rejected_next   = wave_stat.busy && (item.kind != lsfs_pkg::KIND_TICK);
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                lsfs_pkg::CFG_BYTE_CNT:
                    cfg_next.byte_cnt = cfg.data[lsfs_pkg::NUMB_W-1:0];
                lsfs_pkg::CFG_BIT_PERIOD:
                    cfg_next.bit_period = cfg.data[lsfs_pkg::TICK_W-1:0];
                lsfs_pkg::CFG_ONE_HIGH:
                    cfg_next.one_high = cfg.data[lsfs_pkg::TICK_W-1:0];
                lsfs_pkg::CFG_ZERO_HIGH:
                    cfg_next.zero_high = cfg.data[lsfs_pkg::TICK_W-1:0];
                lsfs_pkg::CFG_LATCH_TICKS:
                    cfg_next.latch_ticks = cfg.data[lsfs_pkg::GAP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg          <= 1'b0;
            line_level_reg         <= 1'b0;
            busy_res_reg           <= 1'b0;
            rejected_reg           <= 1'b0;
            cfg_reg.byte_cnt       <= lsfs_pkg::BYTE_CNT_RST;
            cfg_reg.bit_period     <= lsfs_pkg::BIT_PERIOD_RST;
            cfg_reg.one_high       <= lsfs_pkg::ONE_HIGH_RST;
            cfg_reg.zero_high      <= lsfs_pkg::ZERO_HIGH_RST;
            cfg_reg.latch_ticks    <= lsfs_pkg::LATCH_TICKS_RST;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            line_level_reg <= line_level_next;
            busy_res_reg   <= busy_res_next;
            rejected_reg   <= rejected_next;
            cfg_reg        <= cfg_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.line_level = line_level_reg;
    assign result.busy_res   = busy_res_reg;
    assign result.rejected   = rejected_reg;

    lsfs_buf #(
        .MAX_BYTES (MAX_BYTES)
    ) u_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (buf_cmd),
        .wr_addr  (index_ext[AW-1:0]),
        .wr_value (item.value),
        .n_bytes  (n_bytes),
        .adv_addr (adv_addr),
        .ready    (buf_ready),
        .cur_byte (cur_byte)
    );

    lsfs_wave #(
        .MAX_BYTES (MAX_BYTES)
    ) u_wave (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .n_bytes  (n_bytes),
        .cur_byte (cur_byte),
        .cmd      (wave_cmd),
        .stat     (wave_stat),
        .adv_addr (adv_addr)
    );

endmodule

// ===== sim/led_strip_fade_serializer_tb.sv =====
// ----------------------------------------------------------------------------
// led_strip_fade_serializer_tb: self-checking bench for the LED strip driver
// A short directed table walks reset behavior, byte writes, fading, refused
// requests and latch waits. Random requests then run under a series of
// register settings, and every result is checked against an in-bench model
// of the fade buffers and the single-wire waveform timer.
// ----------------------------------------------------------------------------
module led_strip_fade_serializer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES   = 256;
    localparam int CYCLE_LIMIT = 2000000;

    localparam int IDX_W      = lsfs_pkg::IDX_W;
    localparam int BYTE_W     = lsfs_pkg::BYTE_W;
    localparam int NUMB_W     = lsfs_pkg::NUMB_W;
    localparam int TICK_W     = lsfs_pkg::TICK_W;
    localparam int GAP_W      = lsfs_pkg::GAP_W;
    localparam int CFG_DATA_W = lsfs_pkg::CFG_DATA_W;

    typedef lsfs_pkg::kind_t    kind_t;
    typedef lsfs_pkg::cfg_idx_t cfg_idx_t;

    localparam kind_t KIND_TICK   = lsfs_pkg::KIND_TICK;
    localparam kind_t KIND_DIRECT = lsfs_pkg::KIND_DIRECT;
    localparam kind_t KIND_TARGET = lsfs_pkg::KIND_TARGET;
    localparam kind_t KIND_STEP   = lsfs_pkg::KIND_STEP;

    localparam cfg_idx_t CFG_BYTE_CNT    = lsfs_pkg::CFG_BYTE_CNT;
    localparam cfg_idx_t CFG_BIT_PERIOD  = lsfs_pkg::CFG_BIT_PERIOD;
    localparam cfg_idx_t CFG_ONE_HIGH    = lsfs_pkg::CFG_ONE_HIGH;
    localparam cfg_idx_t CFG_ZERO_HIGH   = lsfs_pkg::CFG_ZERO_HIGH;
    localparam cfg_idx_t CFG_LATCH_TICKS = lsfs_pkg::CFG_LATCH_TICKS;

    typedef enum logic [1:0] {LINE_IDLE, LINE_LATCH, LINE_SEND} line_phase_t;

    typedef struct packed {
        logic line_level;
        logic busy;
        logic rejected;
    } strip_res_t;

    localparam strip_res_t IDLE_RES  = '{1'b0, 1'b0, 1'b0};
    localparam strip_res_t FRAME_RES = '{1'b0, 1'b1, 1'b0};

    typedef enum logic {ROW_REQ, ROW_REG} row_op_t;

    typedef struct packed {
        row_op_t               op;
        cfg_idx_t              reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        kind_t                 kind;
        logic [IDX_W-1:0]      index;
        logic [BYTE_W-1:0]     value;
        logic                  last;
        logic [7:0]            reps;
        logic                  typed;
        strip_res_t            want;
    } drill_row_t;

    typedef struct packed {
        logic [NUMB_W-1:0] byte_cnt;
        logic [TICK_W-1:0] bit_period;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] zero_high;
        logic [GAP_W-1:0]  latch_ticks;
        logic [11:0]       count;
    } fade_setting_t;

    logic clk;
    logic rst_n;

    lsfs_item_if   req_ch ();
    lsfs_result_if res_ch ();
    lsfs_cfg_if    reg_ch ();

    led_strip_fade_serializer #(
        .MAX_BYTES (MAX_BYTES)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (reg_ch),
        .item   (req_ch),
        .result (res_ch)
    );

    // Directed table: reset, extremes, refusals while busy, latch wait
    drill_row_t drill [18] = '{
        '{ROW_REQ, CFG_BYTE_CNT, 16'd0, KIND_TICK,   8'h00, 8'h00, 1'b0, 8'd1, 1'b1, IDLE_RES},
        '{ROW_REQ, CFG_BYTE_CNT, 16'd0, KIND_DIRECT, 8'h00, 8'hFF, 1'b0, 8'd1, 1'b1, IDLE_RES},
        '{ROW_REQ, CFG_BYTE_CNT, 16'd0, KIND_DIRECT, 8'hFF, 8'h80, 1'b0, 8'd1, 1'b1, IDLE_RES},
        '{ROW_REQ, CFG_BYTE_CNT, 16'd0, KIND_TARGET, 8'h01, 8'h01, 1'b1, 8'd1, 1'b1, IDLE_RES},
        '{ROW_REQ, CFG_BYTE_CNT, 16'd0, KIND_TARGET, 8'h00, 8'h00, 1'b0, 8'd1, 1'b1, IDLE_RES},
        '{ROW_REG, CFG_BYTE_CNT,    16'd2, KIND_TICK, 8'h00, 8'h00, 1'b0, 8'd1, 1'b0, IDLE_RES},
        '{ROW_REG, CFG_BIT_PERIOD,  16'd4, KIND_TICK, 8'h00, 8'h00, 1'b0, 8'd1, 1'b0, IDLE_RES},
        '{ROW_REG, CFG_ONE_HIGH,    16'd3, KIND_TICK, 8'h00, 8'h00, 1'b0, 8'd1, 1'b0, IDLE_RES},
        '{ROW_REG, CFG_ZERO_HIGH,   16'd1, KIND_TICK, 8'h00, 8'h00, 1'b0, 8'd1, 1'b0, IDLE_RES},
        '{ROW_REG, CFG_LATCH_TICKS, 16'd6, KIND_TICK, 8'h00, 8'h00, 1'b0, 8'd1, 1'b0, IDLE_RES},
        '{ROW_REQ, CFG_BYTE_CNT, 16'd0, KIND_STEP,   8'hAA, 8'h55, 1'b1, 8'd1, 1'b1, FRAME_RES},
        '{ROW_REQ, CFG_BYTE_CNT, 16'd0, KIND_DIRECT, 8'h02, 8'h33, 1'b1, 8'd1, 1'b0, IDLE_RES},
        '{ROW_REQ, CFG_BYTE_CNT, 16'd0, KIND_TARGET, 8'h00, 8'h7F, 1'b0, 8'd1, 1'b0, IDLE_RES},
        '{ROW_REQ, CFG_BYTE_CNT, 16'd0, KIND_STEP,   8'h00, 8'h00, 1'b0, 8'd1, 1'b0, IDLE_RES},
        '{ROW_REQ, CFG_BYTE_CNT, 16'd0, KIND_TICK,   8'h00, 8'h00, 1'b0, 8'd66, 1'b0, IDLE_RES},
        '{ROW_REQ, CFG_BYTE_CNT, 16'd0, KIND_DIRECT, 8'h01, 8'h55, 1'b1, 8'd1, 1'b0, IDLE_RES},
        '{ROW_REQ, CFG_BYTE_CNT, 16'd0, KIND_TICK,   8'h00, 8'h00, 1'b0, 8'd80, 1'b0, IDLE_RES},
        '{ROW_REQ, CFG_BYTE_CNT, 16'd0, KIND_TICK,   8'h5A, 8'hA5, 1'b1, 8'd10, 1'b0, IDLE_RES}
    };

    // Register settings for the random part; the extremes get short runs
    fade_setting_t fade_plan [10] = '{
        '{9'd1,   10'd4,    10'd3,    10'd1, 16'd0,     12'd180},
        '{9'd2,   10'd5,    10'd3,    10'd2, 16'd7,     12'd180},
        '{9'd0,   10'd4,    10'd4,    10'd6, 16'd2,     12'd160},
        '{9'd511, 10'd4,    10'd2,    10'd1, 16'd3,     12'd40},
        '{9'd1,   10'd0,    10'd1,    10'd1, 16'd2,     12'd120},
        '{9'd256, 10'd1023, 10'd1023, 10'd1, 16'd65535, 12'd40},
        '{9'd3,   10'd4,    10'd2,    10'd0, 16'd1,     12'd160},
        '{9'd1,   10'd1,    10'd1,    10'd1, 16'd0,     12'd100},
        '{9'd2,   10'd6,    10'd5,    10'd1, 16'd12,    12'd200},
        '{9'd1,   10'd4,    10'd3,    10'd1, 16'd4,     12'd100}
    };

    // Model state: registers, fade buffers and waveform timer
    logic [NUMB_W-1:0] reg_byte_cnt;
    logic [TICK_W-1:0] reg_bit_period;
    logic [TICK_W-1:0] reg_one_high;
    logic [TICK_W-1:0] reg_zero_high;
    logic [GAP_W-1:0]  reg_latch_ticks;

    logic [BYTE_W-1:0] cur_bytes [MAX_BYTES];
    logic [BYTE_W-1:0] tgt_bytes [MAX_BYTES];
    logic [8:0]        shift_idx;
    logic [2:0]        shift_bit;
    logic [TICK_W-1:0] tick_pos;
    logic [GAP_W-1:0]  gap_left;
    line_phase_t       line_phase;

    strip_res_t line_results_due [$];
    strip_res_t seen_res;
    strip_res_t want_res;

    bit src_steady;
    bit sink_steady;
    int sink_stall;
    int mismatches;
    int results_checked;
    int requests_sent;
    int frames_requested;
    int refused;
    int settings_run;
    int cycle_count;

    function automatic int pick_gap(input bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int strip_len();
        if (reg_byte_cnt == 0)
            return 1;
        if (reg_byte_cnt > MAX_BYTES)
            return MAX_BYTES;
        return int'(reg_byte_cnt);
    endfunction

    function automatic logic held_level();
        logic [BYTE_W-1:0] b;
        logic [TICK_W-1:0] high;
        if (line_phase != LINE_SEND || shift_idx >= MAX_BYTES)
            return 1'b0;
        b = cur_bytes[shift_idx[7:0]];
        high = b[3'd7 - shift_bit] ? reg_one_high : reg_zero_high;
        return tick_pos < high;
    endfunction

    function automatic void open_frame();
        shift_idx = '0;
        shift_bit = '0;
        tick_pos = '0;
        line_phase = (gap_left == 0) ? LINE_SEND : LINE_LATCH;
        frames_requested++;
    endfunction

    // Advance the line by one tick
    function automatic void advance_line();
        case (line_phase)
            LINE_IDLE:
            begin
                if (gap_left != 0)
                    gap_left--;
            end
            LINE_LATCH:
            begin
                if (gap_left != 0)
                    gap_left--;
                if (gap_left == 0)
                    line_phase = LINE_SEND;
            end
            default:
            begin
                tick_pos = tick_pos + 1'b1;
                if (tick_pos >= reg_bit_period || tick_pos == 0)
                begin
                    tick_pos = '0;
                    shift_bit = shift_bit + 1'b1;
                    if (shift_bit == 0)
                    begin
                        shift_idx = shift_idx + 1'b1;
                        if (shift_idx >= strip_len())
                        begin
                            line_phase = LINE_IDLE;
                            shift_idx = '0;
                            gap_left = reg_latch_ticks;
                        end
                    end
                end
            end
        endcase
    endfunction

    // Work out the result of one accepted request and update the model
    function automatic strip_res_t compute_line_result(input kind_t k,
                                                       input logic [IDX_W-1:0] idx,
                                                       input logic [BYTE_W-1:0] val,
                                                       input logic lst);
        strip_res_t r;
        logic       was_busy;
        int         n;
        was_busy = (line_phase != LINE_IDLE);
        r.line_level = held_level();
        r.rejected = 1'b0;
        if (k == KIND_TICK)
            advance_line();
        else if (was_busy)
        begin
            r.rejected = 1'b1;
            refused++;
        end
        else if (k == KIND_DIRECT)
        begin
            if (int'(idx) < MAX_BYTES)
            begin
                cur_bytes[idx] = val;
                tgt_bytes[idx] = val;
            end
            if (lst)
                open_frame();
        end
        else if (k == KIND_TARGET)
        begin
            if (int'(idx) < MAX_BYTES)
                tgt_bytes[idx] = val;
        end
        else
        begin
            n = strip_len();
            for (int i = 0; i < n; i++)
            begin
                if (cur_bytes[i] < tgt_bytes[i])
                    cur_bytes[i] = cur_bytes[i] + 1'b1;
                else if (cur_bytes[i] > tgt_bytes[i])
                    cur_bytes[i] = cur_bytes[i] - 1'b1;
            end
            open_frame();
        end
        r.busy = was_busy || (line_phase != LINE_IDLE);
        return r;
    endfunction

    // Set the bits above a narrow register's width now and then
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                        input int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        if (width >= CFG_DATA_W || $urandom_range(0, 1) == 0)
            return v;
        return v | (junk & ~((CFG_DATA_W'(1) << width) - CFG_DATA_W'(1)));
    endfunction

    // Send one request, predict its result at acceptance
    task automatic send_request(input kind_t k, input logic [IDX_W-1:0] idx,
                                input logic [BYTE_W-1:0] val, input logic lst,
                                input logic typed, input strip_res_t want);
        int         pause;
        strip_res_t predicted;
        pause = pick_gap(src_steady);
        @(negedge clk);
        if (pause > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (pause) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= k;
        req_ch.index <= idx;
        req_ch.value <= val;
        req_ch.last  <= lst;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = compute_line_result(k, idx, val, lst);
        line_results_due.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    // Drop the request line and wait until the block has drained
    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (line_results_due.size() != 0)
            @(posedge clk);
        repeat (MAX_BYTES + 8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= data;
        @(posedge clk);
        while (!reg_ch.ready)
            @(posedge clk);
        case (idx)
            CFG_BYTE_CNT:    reg_byte_cnt    = data[NUMB_W-1:0];
            CFG_BIT_PERIOD:  reg_bit_period  = data[TICK_W-1:0];
            CFG_ONE_HIGH:    reg_one_high    = data[TICK_W-1:0];
            CFG_ZERO_HIGH:   reg_zero_high   = data[TICK_W-1:0];
            CFG_LATCH_TICKS: reg_latch_ticks = data[GAP_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
        reg_ch.valid <= 1'b0;
    endtask

    // Pick a random request: mostly ticks while a frame runs, else edits and frames
    task automatic random_request();
        kind_t             k;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] val;
        logic              lst;
        int                roll;
        roll = $urandom_range(0, 99);
        if (line_phase != LINE_IDLE)
            k = (roll < 90) ? KIND_TICK : kind_t'($urandom_range(1, 3));
        else if (roll < 25)
            k = KIND_TICK;
        else if (roll < 55)
            k = KIND_DIRECT;
        else if (roll < 85)
            k = KIND_TARGET;
        else
            k = KIND_STEP;
        if ($urandom_range(0, 4) != 0)
            idx = IDX_W'($urandom_range(0, strip_len() - 1));
        else
            idx = IDX_W'($urandom_range(0, 255));
        val = BYTE_W'($urandom_range(0, 255));
        if (k == KIND_DIRECT)
            lst = ($urandom_range(0, 4) == 0);
        else
            lst = 1'($urandom_range(0, 1));
        send_request(k, idx, val, lst, 1'b0, IDLE_RES);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random stalls, with calm stretches
    initial
    begin
        res_ch.ready = 1'b0;
        sink_stall = 0;
        sink_steady = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 399) == 0)
                sink_steady = !sink_steady;
            if (sink_stall != 0)
            begin
                res_ch.ready <= 1'b0;
                sink_stall--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                sink_stall = pick_gap(sink_steady);
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (res_ch.valid && res_ch.ready)
        begin
            seen_res = '{res_ch.line_level, res_ch.busy_res, res_ch.rejected};
            if (line_results_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: level %0b busy %0b rejected %0b",
                             seen_res.line_level, seen_res.busy, seen_res.rejected);
                mismatches++;
            end
            else
            begin
                want_res = line_results_due.pop_front();
                if (seen_res !== want_res)
                begin
                    if (mismatches < 10)
                        $display({"result %0d: expected level %0b busy %0b rejected %0b,",
                                  " got level %0b busy %0b rejected %0b"},
                                 results_checked, want_res.line_level, want_res.busy,
                                 want_res.rejected, seen_res.line_level, seen_res.busy,
                                 seen_res.rejected);
                    mismatches++;
                end
            end
            results_checked++;
        end
    end

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind  = KIND_TICK;
        req_ch.index = '0;
        req_ch.value = '0;
        req_ch.last  = 1'b0;
        reg_ch.valid = 1'b0;
        reg_ch.index = CFG_BYTE_CNT;
        reg_ch.data  = '0;
        mismatches = 0;
        results_checked = 0;
        requests_sent = 0;
        frames_requested = 0;
        refused = 0;
        settings_run = 0;
        src_steady = 1'b0;

        reg_byte_cnt    = lsfs_pkg::BYTE_CNT_RST;
        reg_bit_period  = lsfs_pkg::BIT_PERIOD_RST;
        reg_one_high    = lsfs_pkg::ONE_HIGH_RST;
        reg_zero_high   = lsfs_pkg::ZERO_HIGH_RST;
        reg_latch_ticks = lsfs_pkg::LATCH_TICKS_RST;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            cur_bytes[i] = '0;
            tgt_bytes[i] = '0;
        end
        shift_idx = '0;
        shift_bit = '0;
        tick_pos = '0;
        gap_left = '0;
        line_phase = LINE_IDLE;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (drill[i])
        begin
            if (drill[i].op == ROW_REG)
            begin
                settle();
                write_reg(drill[i].reg_idx, drill[i].reg_data);
            end
            else
            begin
                repeat (drill[i].reps)
                    send_request(drill[i].kind, drill[i].index, drill[i].value,
                                 drill[i].last, drill[i].typed, drill[i].want);
            end
        end

        // Random requests under each register setting
        foreach (fade_plan[p])
        begin
            settle();
            write_reg(CFG_BYTE_CNT, with_junk(CFG_DATA_W'(fade_plan[p].byte_cnt), NUMB_W));
            write_reg(CFG_BIT_PERIOD, with_junk(CFG_DATA_W'(fade_plan[p].bit_period), TICK_W));
            write_reg(CFG_ONE_HIGH, with_junk(CFG_DATA_W'(fade_plan[p].one_high), TICK_W));
            write_reg(CFG_ZERO_HIGH, with_junk(CFG_DATA_W'(fade_plan[p].zero_high), TICK_W));
            write_reg(CFG_LATCH_TICKS, fade_plan[p].latch_ticks);
            // Unused register slots must be ignored
            write_reg(cfg_idx_t'(CFG_LATCH_TICKS + 1 + $urandom_range(0, 2)),
                      CFG_DATA_W'($urandom));
            settings_run++;
            src_steady = (p % 3 == 2);
            repeat (fade_plan[p].count)
                random_request();
        end

        settle();
        mismatches += line_results_due.size();

        $display("Checked %0d results for %0d requests across %0d register settings.",
                 results_checked, requests_sent, settings_run);
        $display("Frames requested: %0d, requests refused while busy: %0d.",
                 frames_requested, refused);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== led_strip_fade_serializer.f =====
rtl/core/lsfs_pkg.sv
rtl/core/lsfs_item_if.sv
rtl/core/lsfs_result_if.sv
rtl/core/lsfs_cfg_if.sv
rtl/core/lsfs_ram.sv
rtl/core/lsfs_buf.sv
rtl/core/lsfs_wave.sv
rtl/core/led_strip_fade_serializer.sv
sim/led_strip_fade_serializer_tb.sv
